### rtl/core/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg: shared types and constants of the line sensor steering unit
// field widths, special error codes, drive modes, register map and the
// sensor weight table
// ----------------------------------------------------------------------------
package lsps_pkg;

  // field and datapath widths
  localparam int SENSOR_W = 8;
  localparam int GAIN_W   = 16;
  localparam int BASE_W   = 15;
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = 14;
  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;
  localparam int WSUM_W   = 8;               // weighted sum of set bits
  localparam int MAG_W    = 7;               // magnitude of that sum
  localparam int CNT_W    = 4;               // bit count 0..8
  localparam int DIVR_W   = 3;               // divisor 2..7
  localparam int DELTA_W  = ERR_W + 1;
  localparam int ACC_W    = GAIN_W + 1 + DELTA_W;
  localparam int CLAMP_W  = ACC_W + 2;

  // special error codes
  localparam logic signed [ERR_W-1:0] ERR_CROSS = 14'sd5000;
  localparam logic signed [ERR_W-1:0] ERR_LEFT  = -14'sd1000;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT = 14'sd1000;
  localparam logic signed [ERR_W-1:0] ERR_BOUND = 14'sd50;

  // fixed sensor patterns
  localparam logic [SENSOR_W-1:0] PAT_LEFT_A  = 8'h0F;
  localparam logic [SENSOR_W-1:0] PAT_LEFT_B  = 8'h07;
  localparam logic [SENSOR_W-1:0] PAT_LEFT_C  = 8'h03;
  localparam logic [SENSOR_W-1:0] PAT_RIGHT_A = 8'hF0;
  localparam logic [SENSOR_W-1:0] PAT_RIGHT_B = 8'hE0;
  localparam logic [SENSOR_W-1:0] PAT_RIGHT_C = 8'hC0;
  localparam logic [SENSOR_W-1:0] PAT_WHITE   = 8'hFF;
  localparam logic [CNT_W-1:0]    ZERO_CROSS  = 4'd7;
  localparam logic [CNT_W-1:0]    ZERO_CONF   = 4'd6;

  // speeds, signed Q8.8
  localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 16'sd23040;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN  = -16'sd10240;
  localparam logic signed [SPEED_W-1:0] PIVOT_SPEED = 16'sd15360;
  localparam logic signed [SPEED_W-1:0] SPEED_SAT  = 16'sd32767;
  localparam logic [SPEED_W:0]          CROSS_BOOST = 17'd2560;
  localparam logic signed [CLAMP_W-1:0] CLAMP_HI = CLAMP_W'(23040);
  localparam logic signed [CLAMP_W-1:0] CLAMP_LO = CLAMP_W'(-10240);

  // register reset values
  localparam logic [GAIN_W-1:0] KP_RESET   = 16'd256;
  localparam logic [GAIN_W-1:0] KD_RESET   = 16'd0;
  localparam logic [BASE_W-1:0] BASE_RESET = 15'd10240;

  // sensor weights, bit 0 first
  localparam logic signed [WSUM_W-1:0] WEIGHT [SENSOR_W] =
    '{8'sd50, 8'sd40, 8'sd20, 8'sd10, -8'sd10, -8'sd20, -8'sd40, -8'sd50};

  typedef enum logic [MODE_W-1:0] {
    MODE_PD      = 3'd0,
    MODE_RECHECK = 3'd1,
    MODE_CROSS   = 3'd2,
    MODE_LEFT    = 3'd3,
    MODE_RIGHT   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_CROSS = 2'd1,
    PEND_LEFT  = 2'd2,
    PEND_RIGHT = 2'd3
  } pend_t;

  typedef enum logic [1:0] {
    REG_KP   = 2'd0,
    REG_KD   = 2'd1,
    REG_BASE = 2'd2
  } reg_idx_t;

  // classification of one sensor sample
  typedef struct packed {
    logic              zero6;
    logic              zero7;
    logic              left_pat;
    logic              right_pat;
    logic              all_white;
    logic              sum_neg;
    logic [MAG_W-1:0]  sum_mag;
    logic [CNT_W-1:0]  set_cnt;
  } class_t;

endpackage

### rtl/core/line_sensor_pd_steering_unit.sv
// ----------------------------------------------------------------------------
// line_sensor_pd_steering_unit: pd wheel steering from an 8-bit line sensor
// Special patterns and recheck results other than an unconfirmed crossroad go
// straight to the result; pd with a known error runs the shared multiplier and
// the clamp, pd on the weighted mean first runs the 7-step divider, then two
// passes through the shared multiplier. One sample at a time: the next input
// transfer can come at the earliest in the cycle after the result loads.
// Synchronous reset clears state, pending recheck and previous error, and
// restores the gains and base speed to their defaults.
// ----------------------------------------------------------------------------
module line_sensor_pd_steering_unit
  import lsps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // sample input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SENSOR_W-1:0]       sensor_bits,
  // result output
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SPEED_W-1:0] left_speed,
  output logic signed [SPEED_W-1:0] right_speed,
  output logic [MODE_W-1:0]         drive_mode,
  output logic signed [ERR_W-1:0]   position_error,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DIV      = 6'b000010,
    S_PD_START = 6'b000100,
    S_MAC      = 6'b001000,
    S_CLAMP    = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t                    state;
  logic [GAIN_W-1:0]         kp_gain;
  logic [GAIN_W-1:0]         kd_gain;
  logic [BASE_W-1:0]         base_speed;
  logic signed [ERR_W-1:0]   prev_error;
  pend_t                     pending_check;
  logic signed [ERR_W-1:0]   e_reg;
  logic                      div_neg;
  logic signed [SPEED_W-1:0] res_left;
  logic signed [SPEED_W-1:0] res_right;
  mode_t                     res_mode;
  logic signed [ERR_W-1:0]   res_err;

  class_t                    cls;
  logic                      accept;
  logic                      out_load;
  logic                      cfg_write;
  logic                      samp_known;
  logic                      samp_special;
  logic signed [ERR_W-1:0]   samp_err;
  pend_t                     samp_code;
  logic signed [ERR_W-1:0]   pend_err;
  logic [SPEED_W:0]          boost_sum;
  logic signed [SPEED_W-1:0] boost_speed;
  logic signed [SPEED_W-1:0] base_out;
  logic                      div_start;
  logic                      div_done;
  logic [MAG_W-1:0]          div_quo;
  logic signed [ERR_W-1:0]   quo_ext;
  logic signed [ERR_W-1:0]   div_err;
  logic signed [DELTA_W-1:0] delta;
  logic                      mac_start;
  logic                      mac_done;
  logic signed [ACC_W-1:0]   mac_acc;
  logic signed [CLAMP_W-1:0] base_ext;
  logic signed [CLAMP_W-1:0] acc_ext;
  logic signed [CLAMP_W-1:0] left_raw;
  logic signed [CLAMP_W-1:0] right_raw;

  function automatic logic signed [SPEED_W-1:0] clamp_speed(
    input logic signed [CLAMP_W-1:0] v
  );
    logic signed [SPEED_W-1:0] r;
    if (v > CLAMP_HI) begin
      r = SPEED_MAX;
    end else if (v < CLAMP_LO) begin
      r = SPEED_MIN;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

  // handshake
  assign in_stall  = state != S_IDLE;
  assign accept    = in_valid && (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain    <= KP_RESET;
      kd_gain    <= KD_RESET;
      base_speed <= BASE_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_KP:   kp_gain    <= pwdata[GAIN_W-1:0];
        REG_KD:   kd_gain    <= pwdata[GAIN_W-1:0];
        REG_BASE: base_speed <= pwdata[BASE_W-1:0];
        default:  ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_KP:   prdata = {{(DATA_W-GAIN_W){1'b0}}, kp_gain};
      REG_KD:   prdata = {{(DATA_W-GAIN_W){1'b0}}, kd_gain};
      REG_BASE: prdata = {{(DATA_W-BASE_W){1'b0}}, base_speed};
      default:  prdata = '0;
    endcase
  end

  lsps_classify u_classify (
    .sensor_bits (sensor_bits),
    .cls         (cls)
  );

  // error of a fresh sample where no division is needed
  always_comb begin
    samp_known = 1'b1;
    samp_err   = prev_error;
    if (cls.zero7) begin
      samp_err = ERR_CROSS;
    end else if (cls.left_pat) begin
      samp_err = ERR_LEFT;
    end else if (cls.right_pat) begin
      samp_err = ERR_RIGHT;
    end else if (!cls.all_white) begin
      samp_known = 1'b0;
    end
  end

  always_comb begin
    samp_code = PEND_NONE;
    if (samp_err == ERR_CROSS) begin
      samp_code = PEND_CROSS;
    end else if (samp_err == ERR_LEFT) begin
      samp_code = PEND_LEFT;
    end else if (samp_err == ERR_RIGHT) begin
      samp_code = PEND_RIGHT;
    end
  end

  assign samp_special = samp_known && (samp_code != PEND_NONE);

  // error code of the pending recheck
  always_comb begin
    case (pending_check)
      PEND_LEFT:  pend_err = ERR_LEFT;
      PEND_RIGHT: pend_err = ERR_RIGHT;
      default:    pend_err = ERR_CROSS;
    endcase
  end

  // confirmed crossroad speed, saturated
  assign boost_sum   = {2'b00, base_speed} + CROSS_BOOST;
  assign boost_speed = (boost_sum > {1'b0, SPEED_SAT}) ? SPEED_SAT : boost_sum[SPEED_W-1:0];
  assign base_out    = {1'b0, base_speed};

  // weighted mean divider
  assign div_start = accept && (pending_check == PEND_NONE) && !samp_known;

  lsps_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cls.sum_mag),
    .divisor  (cls.set_cnt[DIVR_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo_ext = {{(ERR_W-MAG_W){1'b0}}, div_quo};
  assign div_err = div_neg ? -quo_ext : quo_ext;

  // pd term
  assign delta     = {e_reg[ERR_W-1], e_reg} - {prev_error[ERR_W-1], prev_error};
  assign mac_start = state == S_PD_START;

  lsps_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .start    (mac_start),
    .kp_gain  (kp_gain),
    .kd_gain  (kd_gain),
    .err_in   (e_reg),
    .delta_in (delta),
    .done     (mac_done),
    .acc      (mac_acc)
  );

  // wheel targets before clamping
  assign base_ext  = {{(CLAMP_W-BASE_W){1'b0}}, base_speed};
  assign acc_ext   = {{(CLAMP_W-ACC_W){mac_acc[ACC_W-1]}}, mac_acc};
  assign left_raw  = base_ext - acc_ext;
  assign right_raw = base_ext + acc_ext;

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pending_check <= PEND_NONE;
      prev_error    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (pending_check != PEND_NONE) begin
              pending_check <= PEND_NONE;
              if (cls.zero6 || (pending_check != PEND_CROSS)) begin
                state <= S_DONE;
              end else begin
                state <= S_PD_START;
              end
            end else if (samp_special) begin
              pending_check <= samp_code;
              state         <= S_DONE;
            end else if (samp_known) begin
              state <= S_PD_START;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV:      if (div_done) state <= S_PD_START;
        S_PD_START: state <= S_MAC;
        S_MAC:      if (mac_done) state <= S_CLAMP;
        S_CLAMP: begin
          prev_error <= e_reg;
          state      <= S_DONE;
        end
        S_DONE:     if (out_load) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  // working error and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          div_neg <= cls.sum_neg;
          if (pending_check != PEND_NONE) begin
            res_err <= pend_err;
            e_reg   <= ERR_CROSS;
            if (cls.zero6) begin
              res_left  <= boost_speed;
              res_right <= boost_speed;
              res_mode  <= MODE_CROSS;
            end else if (pending_check == PEND_LEFT) begin
              res_left  <= -PIVOT_SPEED;
              res_right <= PIVOT_SPEED;
              res_mode  <= MODE_LEFT;
            end else begin
              res_left  <= PIVOT_SPEED;
              res_right <= -PIVOT_SPEED;
              res_mode  <= MODE_RIGHT;
            end
          end else begin
            e_reg     <= samp_err;
            res_err   <= samp_err;
            res_left  <= base_out;
            res_right <= base_out;
            res_mode  <= MODE_RECHECK;
          end
        end
      end
      S_DIV: if (div_done) e_reg <= div_err;
      S_CLAMP: begin
        res_left  <= clamp_speed(left_raw);
        res_right <= clamp_speed(right_raw);
        res_mode  <= MODE_PD;
        res_err   <= e_reg;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_speed     <= res_left;
      right_speed    <= res_right;
      drive_mode     <= res_mode;
      position_error <= res_err;
    end
  end

`ifndef ASSERT_OFF
  // the held error is always a weighted mean or an unconfirmed crossroad
  a_prev_range: assert property (@(posedge clk) disable iff (rst)
    (prev_error == ERR_CROSS) || ((prev_error >= -ERR_BOUND) && (prev_error <= ERR_BOUND)))
    else $error("previous error out of range");

  // a recheck sample always clears the pending recheck
  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && (pending_check != PEND_NONE)) |=> (pending_check == PEND_NONE))
    else $error("pending recheck not cleared");

  // a recheck result is only issued with a recheck armed
  a_recheck_armed: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (res_mode == MODE_RECHECK)) |-> (pending_check != PEND_NONE))
    else $error("recheck result without pending recheck");

  // shared units finish only while the sequencer waits on them
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_mac_done: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_MAC))
    else $error("multiplier finished outside pd state");
`endif

endmodule

### rtl/core/lsps_classify.sv
// ----------------------------------------------------------------------------
// lsps_classify: sensor sample classification
// counts black bits, spots the fixed turn patterns and forms the
// weighted sum and set-bit count for the mean position
// ----------------------------------------------------------------------------
module lsps_classify
  import lsps_pkg::*;
(
  input  logic [SENSOR_W-1:0] sensor_bits,
  output class_t              cls
);

  logic [CNT_W-1:0]         zero_cnt;
  logic signed [WSUM_W-1:0] wsum;
  logic signed [WSUM_W-1:0] wabs;

  // black count and weighted sum over the eight sensors
  always_comb begin
    zero_cnt = '0;
    wsum     = '0;
    for (int i = 0; i < SENSOR_W; i++) begin
      zero_cnt = zero_cnt + {{(CNT_W-1){1'b0}}, ~sensor_bits[i]};
      if (sensor_bits[i]) begin
        wsum = wsum + WEIGHT[i];
      end
    end
  end

  assign wabs = wsum[WSUM_W-1] ? -wsum : wsum;

  // pattern flags
  always_comb begin
    cls.zero6     = zero_cnt >= ZERO_CONF;
    cls.zero7     = zero_cnt >= ZERO_CROSS;
    cls.left_pat  = (sensor_bits == PAT_LEFT_A) || (sensor_bits == PAT_LEFT_B) ||
                    (sensor_bits == PAT_LEFT_C);
    cls.right_pat = (sensor_bits == PAT_RIGHT_A) || (sensor_bits == PAT_RIGHT_B) ||
                    (sensor_bits == PAT_RIGHT_C);
    cls.all_white = sensor_bits == PAT_WHITE;
    cls.sum_neg   = wsum[WSUM_W-1];
    cls.sum_mag   = wabs[MAG_W-1:0];
    cls.set_cnt   = CNT_W'(SENSOR_W) - zero_cnt;
  end

endmodule

### rtl/core/lsps_divider.sv
// ----------------------------------------------------------------------------
// lsps_divider: iterative restoring divider
// one quotient bit per cycle, magnitude over a small unsigned divisor
// ----------------------------------------------------------------------------
module lsps_divider
  import lsps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [MAG_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(MAG_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAG_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [MAG_W-1:0]  dvd;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              fits;

  // trial subtraction of the shifted remainder
  assign trial = {rem, dvd[MAG_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[MAG_W-2:0], 1'b0};
      rem      <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quotient <= {quotient[MAG_W-2:0], fits};
    end
  end

endmodule

### rtl/core/lsps_mac.sv
// ----------------------------------------------------------------------------
// lsps_mac: shared multiply-accumulate for the pd term
// one multiplier used twice: kp * error, then kd * error change, summed
// ----------------------------------------------------------------------------
module lsps_mac
  import lsps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [GAIN_W-1:0]         kp_gain,
  input  logic [GAIN_W-1:0]         kd_gain,
  input  logic signed [ERR_W-1:0]   err_in,
  input  logic signed [DELTA_W-1:0] delta_in,
  output logic                      done,
  output logic signed [ACC_W-1:0]   acc
);

  typedef enum logic [3:0] {
    MAC_IDLE = 4'b0001,
    MAC_KP   = 4'b0010,
    MAC_KD   = 4'b0100,
    MAC_SUM  = 4'b1000
  } mac_phase_t;

  mac_phase_t               phase;
  logic signed [DELTA_W-1:0] err_op;
  logic signed [DELTA_W-1:0] delta_op;
  logic [GAIN_W-1:0]         mul_a;
  logic signed [DELTA_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   prod_full;
  logic signed [ACC_W-1:0]   prod;

  // operand selection for the shared multiplier
  assign mul_a     = (phase == MAC_KP) ? kp_gain : kd_gain;
  assign mul_b     = (phase == MAC_KP) ? err_op : delta_op;
  assign prod_full = $signed({1'b0, mul_a}) * mul_b;

  // phase sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MAC_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        MAC_IDLE: if (start) phase <= MAC_KP;
        MAC_KP:   phase <= MAC_KD;
        MAC_KD:   phase <= MAC_SUM;
        MAC_SUM: begin
          phase <= MAC_IDLE;
          done  <= 1'b1;
        end
        default:  phase <= MAC_IDLE;
      endcase
    end
  end

  // operands, product and accumulator
  always_ff @(posedge clk) begin
    case (phase)
      MAC_IDLE: begin
        if (start) begin
          err_op   <= {err_in[ERR_W-1], err_in};
          delta_op <= delta_in;
        end
      end
      MAC_KP:  prod <= prod_full;
      MAC_KD: begin
        acc  <= prod;
        prod <= prod_full;
      end
      MAC_SUM: acc <= acc + prod;
      default: ;
    endcase
  end

endmodule

### dv/steering_checker.sv
// ----------------------------------------------------------------------------
// steering_checker: result checker for the line sensor steering unit
// Watches the sample, result and configuration ports. Keeps its own copy of
// the gains, base speed, last error and pending recheck, works out the wheel
// command that each accepted sample must give, and compares the results in
// order. Read-back data on the configuration port is checked as well.
// ----------------------------------------------------------------------------
module steering_checker
  import lsps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [SENSOR_W-1:0]       sensor_bits,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [SPEED_W-1:0] left_speed,
  input  logic signed [SPEED_W-1:0] right_speed,
  input  logic [MODE_W-1:0]         drive_mode,
  input  logic signed [ERR_W-1:0]   position_error,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  input  logic [DATA_W-1:0]         prdata,
  input  logic                      pready,
  output int                        fail_count,
  output int                        pending,
  output int                        results_checked
);

  typedef struct packed {
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
    mode_t                     mode;
    logic signed [ERR_W-1:0]   err;
  } wheel_cmd_t;

  wheel_cmd_t              wheel_cmds_due [$];
  wheel_cmd_t              want;
  logic [GAIN_W-1:0]       kp_copy;
  logic [GAIN_W-1:0]       kd_copy;
  logic [BASE_W-1:0]       base_copy;
  logic signed [ERR_W-1:0] last_err;
  pend_t                   recheck;
  logic [DATA_W-1:0]       reg_value;
  int                      fails = 0;
  int                      checked = 0;

  function automatic int zeros_in(input logic [SENSOR_W-1:0] bits);
    int n;
    n = 0;
    for (int i = 0; i < SENSOR_W; i++) begin
      if (!bits[i]) n++;
    end
    return n;
  endfunction

  // error from one sample: special codes first, all-white keeps the last error, else the weighted mean
  function automatic int line_position(input logic [SENSOR_W-1:0] bits);
    int sum;
    int cnt;
    sum = 0;
    cnt = 0;
    if (zeros_in(bits) >= int'(ZERO_CROSS)) return int'(ERR_CROSS);
    if (bits == PAT_LEFT_A || bits == PAT_LEFT_B || bits == PAT_LEFT_C)
      return int'(ERR_LEFT);
    if (bits == PAT_RIGHT_A || bits == PAT_RIGHT_B || bits == PAT_RIGHT_C)
      return int'(ERR_RIGHT);
    if (bits == PAT_WHITE) return int'(last_err);
    for (int i = 0; i < SENSOR_W; i++) begin
      if (bits[i]) begin
        sum += int'(WEIGHT[i]);
        cnt++;
      end
    end
    if (cnt == 0) return int'(last_err);
    return sum / cnt;
  endfunction

  function automatic int clamp_q88(input longint v);
    if (v > longint'(SPEED_MAX)) return int'(SPEED_MAX);
    if (v < longint'(SPEED_MIN)) return int'(SPEED_MIN);
    return int'(v);
  endfunction

  // proportional plus derivative steering, updates the last error
  function automatic void pd_wheels(input int e, output int l, output int r);
    longint diff;
    diff = longint'(kp_copy) * e + longint'(kd_copy) * (e - int'(last_err));
    last_err = ERR_W'(e);
    l = clamp_q88(longint'(base_copy) - diff);
    r = clamp_q88(longint'(base_copy) + diff);
  endfunction

  function automatic wheel_cmd_t predict_wheels(input logic [SENSOR_W-1:0] bits);
    wheel_cmd_t c;
    int         e;
    int         l;
    int         r;
    int         s;
    mode_t      m;
    if (recheck != PEND_NONE) begin
      // second look after a special pattern
      case (recheck)
        PEND_CROSS: e = int'(ERR_CROSS);
        PEND_LEFT:  e = int'(ERR_LEFT);
        default:    e = int'(ERR_RIGHT);
      endcase
      if (zeros_in(bits) >= int'(ZERO_CONF)) begin
        s = int'(base_copy) + int'(CROSS_BOOST);
        if (s > int'(SPEED_SAT)) s = int'(SPEED_SAT);
        l = s;
        r = s;
        m = MODE_CROSS;
      end else if (recheck == PEND_LEFT) begin
        l = -int'(PIVOT_SPEED);
        r = int'(PIVOT_SPEED);
        m = MODE_LEFT;
      end else if (recheck == PEND_RIGHT) begin
        l = int'(PIVOT_SPEED);
        r = -int'(PIVOT_SPEED);
        m = MODE_RIGHT;
      end else begin
        pd_wheels(e, l, r);
        m = MODE_PD;
      end
      recheck = PEND_NONE;
    end else begin
      e = line_position(bits);
      if (e == int'(ERR_CROSS) || e == int'(ERR_LEFT) || e == int'(ERR_RIGHT)) begin
        l = int'(base_copy);
        r = int'(base_copy);
        m = MODE_RECHECK;
        if (e == int'(ERR_CROSS)) recheck = PEND_CROSS;
        else if (e == int'(ERR_LEFT)) recheck = PEND_LEFT;
        else recheck = PEND_RIGHT;
      end else begin
        pd_wheels(e, l, r);
        m = MODE_PD;
      end
    end
    c.left  = SPEED_W'(l);
    c.right = SPEED_W'(r);
    c.mode  = m;
    c.err   = ERR_W'(e);
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kp_copy   = KP_RESET;
      kd_copy   = KD_RESET;
      base_copy = BASE_RESET;
      last_err  = '0;
      recheck   = PEND_NONE;
      wheel_cmds_due.delete();
    end else begin
      // result transfer against the oldest outstanding command
      if (out_valid && !out_stall) begin
        if (wheel_cmds_due.size() == 0) begin
          $error("result with nothing outstanding: left %0d right %0d mode %0d err %0d",
                 left_speed, right_speed, drive_mode, position_error);
          fails++;
        end else begin
          want = wheel_cmds_due.pop_front();
          checked++;
          if (left_speed !== want.left) begin
            $error("left_speed: expected %0d, got %0d", want.left, left_speed);
            fails++;
          end
          if (right_speed !== want.right) begin
            $error("right_speed: expected %0d, got %0d", want.right, right_speed);
            fails++;
          end
          if (drive_mode !== want.mode) begin
            $error("drive_mode: expected %0d, got %0d", want.mode, drive_mode);
            fails++;
          end
          if (position_error !== want.err) begin
            $error("position_error: expected %0d, got %0d", want.err, position_error);
            fails++;
          end
        end
      end

      // configuration access, write or read-back
      if (psel && penable && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_KP:   reg_value = DATA_W'(kp_copy);
          REG_KD:   reg_value = DATA_W'(kd_copy);
          REG_BASE: reg_value = DATA_W'(base_copy);
          default:  reg_value = '0;
        endcase
        if (pwrite) begin
          case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_KP:   kp_copy   = pwdata[GAIN_W-1:0];
            REG_KD:   kd_copy   = pwdata[GAIN_W-1:0];
            REG_BASE: base_copy = pwdata[BASE_W-1:0];
            default:  ;
          endcase
        end else if (paddr[ADDR_W-1:2] <= REG_BASE && prdata !== reg_value) begin
          $error("prdata at %0d: expected %0d, got %0d", paddr, reg_value, prdata);
          fails++;
        end
      end

      // sample transfer
      if (in_valid && !in_stall) wheel_cmds_due.push_back(predict_wheels(sensor_bits));
    end
    fail_count      <= fails;
    pending         <= wheel_cmds_due.size();
    results_checked <= checked;
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top of the line sensor steering unit testbench
// Drives a directed run through every special pattern and recheck outcome,
// then random samples under several gain and base speed settings, with
// random idle and stall bursts. The checker beside the unit does the checking.
// ----------------------------------------------------------------------------
module testbench;
  import lsps_pkg::*;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int RAND_PER_PHASE = 254;
  localparam int PHASES         = 6;
  localparam int TAIL_CYCLES    = 40;
  localparam logic [ADDR_W-1:0] ADDR_SPARE = 4'd12;
  localparam logic [SENSOR_W-1:0] TURN_PATS [6] =
    '{PAT_LEFT_A, PAT_LEFT_B, PAT_LEFT_C, PAT_RIGHT_A, PAT_RIGHT_B, PAT_RIGHT_C};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [SENSOR_W-1:0]       sensor_bits = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic [MODE_W-1:0]         drive_mode;
  logic signed [ERR_W-1:0]   position_error;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int fail_count;
  int pending;
  int results_checked;
  int cycle_count = 0;
  int stall_left = 0;
  int samples_sent = 0;
  int settings_used = 0;
  bit idle_on = 1'b1;

  line_sensor_pd_steering_unit dut (
    .clk, .rst, .in_valid, .in_stall, .sensor_bits,
    .out_valid, .out_stall, .left_speed, .right_speed, .drive_mode, .position_error,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  steering_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .sensor_bits,
    .out_valid, .out_stall, .left_speed, .right_speed, .drive_mode, .position_error,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending, .results_checked
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one sample transfer, with an optional idle burst in front
  task automatic send_sample(input logic [SENSOR_W-1:0] bits);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sensor_bits <= bits;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // drop valid and wait until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_access(input bit is_write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_steering(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                              input logic [BASE_W-1:0] base);
    apb_access(1'b1, {REG_KP, 2'b00}, DATA_W'(kp));
    apb_access(1'b1, {REG_KD, 2'b00}, DATA_W'(kd));
    apb_access(1'b1, {REG_BASE, 2'b00}, DATA_W'(base));
    apb_access(1'b0, {REG_KP, 2'b00}, '0);
    apb_access(1'b0, {REG_KD, 2'b00}, '0);
    apb_access(1'b0, {REG_BASE, 2'b00}, '0);
    settings_used++;
  endtask

  // random sample, weighted towards special patterns and recheck outcomes
  function automatic logic [SENSOR_W-1:0] random_sample();
    logic [SENSOR_W-1:0] bits;
    case ($urandom_range(0, 9))
      0, 1:    bits = TURN_PATS[$urandom_range(0, 5)];
      2:       bits = $urandom_range(0, 1) ? SENSOR_W'(1 << $urandom_range(0, 7)) : '0;
      3:       bits = SENSOR_W'(1 << $urandom_range(0, 7)) | SENSOR_W'(1 << $urandom_range(0, 7));
      4:       bits = PAT_WHITE;
      default: bits = SENSOR_W'($urandom_range(0, 255));
    endcase
    return bits;
  endfunction

  initial begin
    logic [SENSOR_W-1:0] directed_seq [$];
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   kd;
    logic [BASE_W-1:0]   base;

    // crossroad confirmed, all-white hold, unconfirmed crossroad and its
    // held error, turns confirmed, turns taken over by a crossroad, plain samples
    directed_seq = '{8'h00, 8'h00, 8'hFF, 8'h01, 8'h5A, 8'hFF, 8'hFF,
                     8'h0F, 8'h3F, 8'hF0, 8'hAA, 8'h07, 8'h01, 8'hE0, 8'h03,
                     8'h03, 8'hF7, 8'hC0, 8'h7E, 8'h18, 8'h81, 8'h7F, 8'hFE,
                     8'h55, 8'h24};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part on reset settings
    foreach (directed_seq[i]) send_sample(directed_seq[i]);
    drain();
    apb_access(1'b1, ADDR_SPARE, DATA_W'($urandom));

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin kp = '0;            kd = '0;            base = '0;           end
        1: begin kp = '1;            kd = '1;            base = '1;           end
        2: begin kp = '1;            kd = '0;            base = SPEED_MAX[BASE_W-1:0]; end
        3: begin
          kp   = GAIN_W'($urandom_range(0, 65535));
          kd   = GAIN_W'($urandom_range(0, 65535));
          base = BASE_W'($urandom_range(0, 23040));
        end
        4: begin kp = KP_RESET;      kd = GAIN_W'(1024); base = BASE_RESET;   end
        default: begin
          kp   = GAIN_W'($urandom_range(0, 2048));
          kd   = GAIN_W'($urandom_range(0, 2048));
          base = BASE_W'($urandom_range(0, 32767));
        end
      endcase
      // no idling in the closing phase
      if (phase == PHASES - 1) idle_on <= 1'b0;
      set_steering(kp, kd, base);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // in phase 2, hold off once mid-phase until the unit has caught up
        if (phase == 2 && n == RAND_PER_PHASE / 2) drain();
        send_sample(random_sample());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);

    $display("ran %0d sensor samples under %0d register settings, %0d results checked",
             samples_sent, settings_used + 1, results_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
